// File: rtl/ddg_pkg.sv
// Shared types, constants and helper functions for the go-to-point controller.
package ddg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CfgW     = 24;
  localparam int CfgIdxW  = 3;
  localparam int VW       = 50;
  localparam int ZW       = 36;
  localparam int RW       = 34;
  localparam int DW       = 38;
  localparam int LenW     = 35;
  localparam int CmdW     = 17;
  localparam int DivSteps = 16;
  localparam int NumW     = 40;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [RW-1:0] K_Q30       = 34'sd652032874;
  localparam logic [15:0]          K_Q16       = 16'd39797;
  localparam logic signed [23:0]   PI_Q16      = 24'sd205887;
  localparam logic signed [23:0]   TWO_PI_Q16  = 24'sd411775;
  localparam logic signed [DW-1:0] SAT_LIM     = 38'sd68719476735;
  localparam logic signed [CmdW-1:0] NOT_READY_CMD = 17'sd1638;
  localparam logic signed [CmdW-1:0] CMD_MAX       = 17'sd32768;

  localparam logic [CfgW-1:0] POS_GAIN_RST  = 24'd65536;
  localparam logic [CfgW-1:0] VEL_GAIN_RST  = 24'd65536;
  localparam logic [CfgW-1:0] HEAD_GAIN_RST = 24'd65536;
  localparam logic [CfgW-1:0] WHEEL_BASE_RST = 24'd19661;
  localparam logic [CfgW-1:0] SPEED_LIM_RST = 24'd65536;

  typedef enum logic [2:0] {
    KIND_DISARMED  = 3'd0,
    KIND_NOT_READY = 3'd1,
    KIND_LANDING   = 3'd2,
    KIND_RAW       = 3'd3,
    KIND_TRACK     = 3'd4
  } ddg_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POSITION_GAIN = 3'd0,
    CFG_VELOCITY_GAIN = 3'd1,
    CFG_HEADING_GAIN  = 3'd2,
    CFG_WHEEL_BASE    = 3'd3,
    CFG_SPEED_LIMIT   = 3'd4
  } ddg_cfg_idx_t;

  typedef struct packed {
    logic                   valid;
    logic                   track;
    logic                   zero;
    logic                   neg_e;
    logic                   neg_y;
    logic signed [CmdW-1:0] byp_r;
    logic signed [CmdW-1:0] byp_l;
    logic signed [19:0]     yaw;
    logic signed [23:0]     vx;
    logic signed [23:0]     vy;
    logic signed [19:0]     err;
    logic [LenW-1:0]        len;
  } ddg_tag_t;

  typedef struct packed {
    logic                   valid;
    logic                   track;
    logic                   zlim;
    logic                   neg_r;
    logic                   neg_l;
    logic signed [CmdW-1:0] byp_r;
    logic signed [CmdW-1:0] byp_l;
  } ddg_div_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    case (i)
      0:  return 36'sd843314856;
      1:  return 36'sd497837829;
      2:  return 36'sd263043836;
      3:  return 36'sd133525158;
      4:  return 36'sd67021686;
      5:  return 36'sd33543515;
      6:  return 36'sd16775850;
      7:  return 36'sd8388437;
      8:  return 36'sd4194282;
      9:  return 36'sd2097149;
      10: return 36'sd1048575;
      11: return 36'sd524287;
      12: return 36'sd262143;
      13: return 36'sd131071;
      14: return 36'sd65535;
      15: return 36'sd32767;
      16: return 36'sd16383;
      17: return 36'sd8191;
      18: return 36'sd4095;
      19: return 36'sd2047;
      20: return 36'sd1023;
      21: return 36'sd511;
      22: return 36'sd255;
      23: return 36'sd127;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] sat38(input logic signed [63:0] v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [23:0] wrap16(input logic signed [23:0] a);
    if (a > PI_Q16) return a - TWO_PI_Q16;
    if (a < -PI_Q16) return a + TWO_PI_Q16;
    return a;
  endfunction

  function automatic logic signed [ZW-1:0] fold_z(input logic signed [ZW-1:0] z);
    if (z > HALF_PI_Q30) return z - PI_Q30;
    if (z < -HALF_PI_Q30) return z + PI_Q30;
    return z;
  endfunction

  function automatic logic fold_neg(input logic signed [ZW-1:0] z);
    return (z > HALF_PI_Q30) || (z < -HALF_PI_Q30);
  endfunction

  function automatic logic signed [17:0] rnd_cs(input logic signed [RW-1:0] x, input logic neg);
    logic signed [RW-1:0] v;
    v = neg ? -x : x;
    v = v + RW'(8192);
    return v[31:14];
  endfunction

endpackage

// File: rtl/ddg_vec_cell.sv
// One CORDIC vectoring iteration with its pipeline register.
module ddg_vec_cell import ddg_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddg_tag_t             tag_i,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ddg_tag_t             tag_o,
  output logic signed [VW-1:0] x_o,
  output logic signed [VW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  ddg_tag_t             tag_r;
  logic signed [VW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> Idx);
      y_nxt = y_i - (x_i >>> Idx);
      z_nxt = z_i + atan_q30(Idx);
    end else begin
      x_nxt = x_i - (y_i >>> Idx);
      y_nxt = y_i + (x_i >>> Idx);
      z_nxt = z_i - atan_q30(Idx);
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_i;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// File: rtl/ddg_rot_cell.sv
// One CORDIC rotation iteration on two lanes with its pipeline register.
module ddg_rot_cell import ddg_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddg_tag_t             tag_i,
  input  logic signed [RW-1:0] xa_i,
  input  logic signed [RW-1:0] ya_i,
  input  logic signed [ZW-1:0] za_i,
  input  logic signed [RW-1:0] xb_i,
  input  logic signed [RW-1:0] yb_i,
  input  logic signed [ZW-1:0] zb_i,
  output ddg_tag_t             tag_o,
  output logic signed [RW-1:0] xa_o,
  output logic signed [RW-1:0] ya_o,
  output logic signed [ZW-1:0] za_o,
  output logic signed [RW-1:0] xb_o,
  output logic signed [RW-1:0] yb_o,
  output logic signed [ZW-1:0] zb_o
);

  ddg_tag_t             tag_r;
  logic signed [RW-1:0] xa_r, ya_r, xb_r, yb_r;
  logic signed [RW-1:0] xa_nxt, ya_nxt, xb_nxt, yb_nxt;
  logic signed [ZW-1:0] za_r, zb_r, za_nxt, zb_nxt;

  always_comb begin
    if (za_i >= 0) begin
      xa_nxt = xa_i - (ya_i >>> Idx);
      ya_nxt = ya_i + (xa_i >>> Idx);
      za_nxt = za_i - atan_q30(Idx);
    end else begin
      xa_nxt = xa_i + (ya_i >>> Idx);
      ya_nxt = ya_i - (xa_i >>> Idx);
      za_nxt = za_i + atan_q30(Idx);
    end
    if (zb_i >= 0) begin
      xb_nxt = xb_i - (yb_i >>> Idx);
      yb_nxt = yb_i + (xb_i >>> Idx);
      zb_nxt = zb_i - atan_q30(Idx);
    end else begin
      xb_nxt = xb_i + (yb_i >>> Idx);
      yb_nxt = yb_i - (xb_i >>> Idx);
      zb_nxt = zb_i + atan_q30(Idx);
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_i;
    xa_r  <= xa_nxt;
    ya_r  <= ya_nxt;
    za_r  <= za_nxt;
    xb_r  <= xb_nxt;
    yb_r  <= yb_nxt;
    zb_r  <= zb_nxt;
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end
  end

  assign tag_o = tag_r;
  assign xa_o  = xa_r;
  assign ya_o  = ya_r;
  assign za_o  = za_r;
  assign xb_o  = xb_r;
  assign yb_o  = yb_r;
  assign zb_o  = zb_r;

endmodule

// File: rtl/ddg_div_cell.sv
// One restoring-division step on the right and left lanes with its pipeline register.
module ddg_div_cell import ddg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CfgW-1:0]     lim,
  input  ddg_div_t            st_i,
  input  logic [CfgW-1:0]     rem_r_i,
  input  logic [CfgW-1:0]     rem_l_i,
  input  logic [DivSteps-1:0] nlo_r_i,
  input  logic [DivSteps-1:0] nlo_l_i,
  input  logic [DivSteps-1:0] q_r_i,
  input  logic [DivSteps-1:0] q_l_i,
  output ddg_div_t            st_o,
  output logic [CfgW-1:0]     rem_r_o,
  output logic [CfgW-1:0]     rem_l_o,
  output logic [DivSteps-1:0] nlo_r_o,
  output logic [DivSteps-1:0] nlo_l_o,
  output logic [DivSteps-1:0] q_r_o,
  output logic [DivSteps-1:0] q_l_o
);

  ddg_div_t            st_r;
  logic [CfgW:0]       tr, tl;
  logic [CfgW-1:0]     rem_r_r, rem_l_r, rem_r_nxt, rem_l_nxt;
  logic [DivSteps-1:0] nlo_r_r, nlo_l_r, q_r_r, q_l_r, q_r_nxt, q_l_nxt;

  always_comb begin
    tr = {rem_r_i, nlo_r_i[DivSteps-1]};
    tl = {rem_l_i, nlo_l_i[DivSteps-1]};
    if (tr >= {1'b0, lim}) begin
      rem_r_nxt = CfgW'(tr - {1'b0, lim});
      q_r_nxt   = {q_r_i[DivSteps-2:0], 1'b1};
    end else begin
      rem_r_nxt = tr[CfgW-1:0];
      q_r_nxt   = {q_r_i[DivSteps-2:0], 1'b0};
    end
    if (tl >= {1'b0, lim}) begin
      rem_l_nxt = CfgW'(tl - {1'b0, lim});
      q_l_nxt   = {q_l_i[DivSteps-2:0], 1'b1};
    end else begin
      rem_l_nxt = tl[CfgW-1:0];
      q_l_nxt   = {q_l_i[DivSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_i;
    rem_r_r <= rem_r_nxt;
    rem_l_r <= rem_l_nxt;
    nlo_r_r <= {nlo_r_i[DivSteps-2:0], 1'b0};
    nlo_l_r <= {nlo_l_i[DivSteps-2:0], 1'b0};
    q_r_r   <= q_r_nxt;
    q_l_r   <= q_l_nxt;
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end
  end

  assign st_o    = st_r;
  assign rem_r_o = rem_r_r;
  assign rem_l_o = rem_l_r;
  assign nlo_r_o = nlo_r_r;
  assign nlo_l_o = nlo_l_r;
  assign q_r_o   = q_r_r;
  assign q_l_o   = q_l_r;

  ap_rem_below_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.valid && st_r.track && lim != '0) |-> (rem_r_r < lim && rem_l_r < lim))
    else $error("division remainder not below speed limit");

endmodule

// File: rtl/diff_drive_goto_point_controller.sv
// Top level of the differential-drive go-to-point controller and wheel mixer.
// Throughput: one transaction per cycle while busy is low; set by the vectoring
// and rotation CORDIC cell chains and the 16-cell divider chain, all fully pipelined.
// Reset: synchronous, active low; clears the pipeline, loads register defaults, busy high.
module diff_drive_goto_point_controller import ddg_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_kind,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [23:0]     in_vel_x,
  input  logic signed [23:0]     in_vel_y,
  input  logic signed [19:0]     in_yaw,
  input  logic signed [31:0]     in_target_x,
  input  logic signed [31:0]     in_target_y,
  input  logic signed [CmdW-1:0] in_raw_right,
  input  logic signed [CmdW-1:0] in_raw_left,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]        cfg_data,
  output logic                   out_valid,
  output logic signed [CmdW-1:0] out_right_cmd,
  output logic signed [CmdW-1:0] out_left_cmd
);

  localparam int LpW = VW - 9 + 16;

  logic [CfgW-1:0] pos_gain_r, vel_gain_r, head_gain_r, wheel_base_r, speed_limit_r;
  logic            busy_r;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
    if (!rst_n) begin
      pos_gain_r    <= POS_GAIN_RST;
      vel_gain_r    <= VEL_GAIN_RST;
      head_gain_r   <= HEAD_GAIN_RST;
      wheel_base_r  <= WHEEL_BASE_RST;
      speed_limit_r <= SPEED_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POSITION_GAIN: pos_gain_r    <= cfg_data;
        CFG_VELOCITY_GAIN: vel_gain_r    <= cfg_data;
        CFG_HEADING_GAIN:  head_gain_r   <= cfg_data;
        CFG_WHEEL_BASE:    wheel_base_r  <= cfg_data;
        CFG_SPEED_LIMIT:   speed_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = busy_r;

  // input stage
  logic signed [32:0]     ex, ey;
  logic signed [VW-1:0]   x0, y0, s0_x_r, s0_y_r;
  logic signed [ZW-1:0]   z0, s0_z_r;
  logic signed [23:0]     yaw_w;
  logic signed [CmdW-1:0] byp_r, byp_l;
  ddg_tag_t               s0_tag_nxt, s0_tag_r;

  assign ex = 33'(in_target_x) - 33'(in_pos_x);
  assign ey = 33'(in_target_y) - 33'(in_pos_y);

  always_comb begin
    x0 = VW'(ex) <<< 14;
    y0 = VW'(ey) <<< 14;
    z0 = '0;
    if (x0 < 0) begin
      z0 = (y0 >= 0) ? PI_Q30 : -PI_Q30;
      x0 = -x0;
      y0 = -y0;
    end
    yaw_w = wrap16(24'(in_yaw));
    byp_r = '0;
    byp_l = '0;
    case (in_kind)
      KIND_NOT_READY: begin
        byp_r = NOT_READY_CMD;
        byp_l = NOT_READY_CMD;
      end
      KIND_RAW: begin
        byp_r = in_raw_right;
        byp_l = in_raw_left;
        if (in_raw_right > CMD_MAX) byp_r = CMD_MAX;
        if (in_raw_right < -CMD_MAX) byp_r = -CMD_MAX;
        if (in_raw_left > CMD_MAX) byp_l = CMD_MAX;
        if (in_raw_left < -CMD_MAX) byp_l = -CMD_MAX;
      end
      default: ;
    endcase
    s0_tag_nxt       = '0;
    s0_tag_nxt.valid = start && !busy_r;
    s0_tag_nxt.track = (in_kind == KIND_TRACK);
    s0_tag_nxt.zero  = (ex == '0) && (ey == '0);
    s0_tag_nxt.byp_r = byp_r;
    s0_tag_nxt.byp_l = byp_l;
    s0_tag_nxt.yaw   = yaw_w[19:0];
    s0_tag_nxt.vx    = in_vel_x;
    s0_tag_nxt.vy    = in_vel_y;
  end

  always_ff @(posedge clk) begin
    s0_tag_r <= s0_tag_nxt;
    s0_x_r   <= x0;
    s0_y_r   <= y0;
    s0_z_r   <= z0;
    if (!rst_n) begin
      s0_tag_r.valid <= 1'b0;
    end
  end

  // vectoring chain
  ddg_tag_t             vtag [0:CORDIC_STEPS];
  logic signed [VW-1:0] vx_c [0:CORDIC_STEPS];
  logic signed [VW-1:0] vy_c [0:CORDIC_STEPS];
  logic signed [ZW-1:0] vz_c [0:CORDIC_STEPS];

  assign vtag[0] = s0_tag_r;
  assign vx_c[0] = s0_x_r;
  assign vy_c[0] = s0_y_r;
  assign vz_c[0] = s0_z_r;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_vec
    ddg_vec_cell #(.Idx(gi)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (vtag[gi]),
      .x_i   (vx_c[gi]),
      .y_i   (vy_c[gi]),
      .z_i   (vz_c[gi]),
      .tag_o (vtag[gi+1]),
      .x_o   (vx_c[gi+1]),
      .y_o   (vy_c[gi+1]),
      .z_o   (vz_c[gi+1])
    );
  end

  // bearing, heading error, length product
  logic signed [ZW-1:0] zr;
  logic signed [21:0]   bear;
  logic signed [23:0]   e24;
  logic signed [VW-1:0] xpos;
  logic [LpW-1:0]       lp, s1_lp_r;
  ddg_tag_t             s1_tag_nxt, s1_tag_r;

  always_comb begin
    zr   = vz_c[CORDIC_STEPS] + ZW'(8192);
    bear = $signed(zr[ZW-1:14]);
    if (vtag[CORDIC_STEPS].zero) bear = '0;
    e24  = 24'(bear) - 24'(vtag[CORDIC_STEPS].yaw);
    e24  = wrap16(wrap16(e24));
    xpos = (vx_c[CORDIC_STEPS] < 0) ? '0 : vx_c[CORDIC_STEPS];
    lp   = xpos[VW-2:8] * K_Q16;
    s1_tag_nxt     = vtag[CORDIC_STEPS];
    s1_tag_nxt.err = e24[19:0];
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= s1_tag_nxt;
    s1_lp_r  <= lp;
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
    end
  end

  // length, rotation set-up
  logic [LpW-1:0]       lsum;
  logic signed [ZW-1:0] za0, zy0;
  logic signed [ZW-1:0] s2_za_r, s2_zb_r;
  ddg_tag_t             s2_tag_nxt, s2_tag_r;

  always_comb begin
    lsum = s1_lp_r + LpW'(2097152);
    za0  = ZW'(s1_tag_r.err) <<< 14;
    zy0  = ZW'(s1_tag_r.yaw) <<< 14;
    s2_tag_nxt       = s1_tag_r;
    s2_tag_nxt.len   = s1_tag_r.zero ? '0 : lsum[LpW-1:22];
    s2_tag_nxt.neg_e = fold_neg(za0);
    s2_tag_nxt.neg_y = fold_neg(zy0);
  end

  always_ff @(posedge clk) begin
    s2_tag_r <= s2_tag_nxt;
    s2_za_r  <= fold_z(za0);
    s2_zb_r  <= fold_z(zy0);
    if (!rst_n) begin
      s2_tag_r.valid <= 1'b0;
    end
  end

  // rotation chain: lane a heading error, lane b yaw
  ddg_tag_t             rtag [0:CORDIC_STEPS];
  logic signed [RW-1:0] rxa [0:CORDIC_STEPS];
  logic signed [RW-1:0] rya [0:CORDIC_STEPS];
  logic signed [ZW-1:0] rza [0:CORDIC_STEPS];
  logic signed [RW-1:0] rxb [0:CORDIC_STEPS];
  logic signed [RW-1:0] ryb [0:CORDIC_STEPS];
  logic signed [ZW-1:0] rzb [0:CORDIC_STEPS];

  assign rtag[0] = s2_tag_r;
  assign rxa[0]  = K_Q30;
  assign rya[0]  = '0;
  assign rza[0]  = s2_za_r;
  assign rxb[0]  = K_Q30;
  assign ryb[0]  = '0;
  assign rzb[0]  = s2_zb_r;

  for (genvar gr = 0; gr < CORDIC_STEPS; gr++) begin : g_rot
    ddg_rot_cell #(.Idx(gr)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (rtag[gr]),
      .xa_i  (rxa[gr]),
      .ya_i  (rya[gr]),
      .za_i  (rza[gr]),
      .xb_i  (rxb[gr]),
      .yb_i  (ryb[gr]),
      .zb_i  (rzb[gr]),
      .tag_o (rtag[gr+1]),
      .xa_o  (rxa[gr+1]),
      .ya_o  (rya[gr+1]),
      .za_o  (rza[gr+1]),
      .xb_o  (rxb[gr+1]),
      .yb_o  (ryb[gr+1]),
      .zb_o  (rzb[gr+1])
    );
  end

  // cos/sin rounding
  ddg_tag_t           s3_tag_r;
  logic signed [17:0] s3_ce_r, s3_cy_r, s3_sy_r;

  always_ff @(posedge clk) begin
    s3_tag_r <= rtag[CORDIC_STEPS];
    s3_ce_r  <= rnd_cs(rxa[CORDIC_STEPS], rtag[CORDIC_STEPS].neg_e);
    s3_cy_r  <= rnd_cs(rxb[CORDIC_STEPS], rtag[CORDIC_STEPS].neg_y);
    s3_sy_r  <= rnd_cs(ryb[CORDIC_STEPS], rtag[CORDIC_STEPS].neg_y);
    if (!rst_n) begin
      s3_tag_r.valid <= 1'b0;
    end
  end

  ddg_div_t s3_side;

  always_comb begin
    s3_side       = '0;
    s3_side.valid = s3_tag_r.valid;
    s3_side.track = s3_tag_r.track;
    s3_side.byp_r = s3_tag_r.byp_r;
    s3_side.byp_l = s3_tag_r.byp_l;
  end

  // control law pipeline
  ddg_div_t           p1_side_r, p2_side_r, p3_side_r, p4_side_r, p5_side_r, p6_side_r;
  ddg_div_t           p7_side_r;
  logic signed [41:0] p1_mvx_r, p1_mvy_r;
  logic [58:0]        p1_md_r;
  logic signed [44:0] p1_mang_r;
  logic signed [17:0] p1_ce_r, p2_ce_r;
  logic signed [42:0] vsum;
  logic [58:0]        dsum;
  logic signed [44:0] asum;
  logic signed [26:0] p2_vfwd_r, p3_vfwd_r, p4_vfwd_r;
  logic signed [DW-1:0] p2_d0_r;
  logic signed [28:0] p2_ang_r;
  logic signed [55:0] p3_mdc_r;
  logic signed [53:0] p3_mterm_r;
  logic signed [55:0] dcs;
  logic signed [53:0] tms;
  logic signed [DW-1:0] p4_d1_r, p5_d1_r, p6_d1_r;
  logic signed [36:0] p4_term_r, p5_term_r, p6_term_r, p7_term_r;
  logic signed [DW-1:0] p5_diff_r;
  logic signed [62:0] p6_mkv_r;
  logic signed [62:0] kvs;
  logic signed [DW-1:0] p7_lin_r;

  always_comb begin
    vsum = 43'(p1_mvx_r) + 43'(p1_mvy_r) + 43'sd32768;
    dsum = p1_md_r + 59'd32768;
    asum = p1_mang_r + 45'sd32768;
    dcs  = p3_mdc_r + 56'sd32768;
    tms  = p3_mterm_r + 54'sd65536;
    kvs  = p6_mkv_r + 63'sd32768;
  end

  always_ff @(posedge clk) begin
    p1_side_r <= s3_side;
    p1_mvx_r  <= s3_cy_r * s3_tag_r.vx;
    p1_mvy_r  <= s3_sy_r * s3_tag_r.vy;
    p1_md_r   <= s3_tag_r.len * pos_gain_r;
    p1_mang_r <= $signed({1'b0, head_gain_r}) * s3_tag_r.err;
    p1_ce_r   <= s3_ce_r;

    p2_side_r <= p1_side_r;
    p2_vfwd_r <= $signed(vsum[42:16]);
    p2_d0_r   <= (dsum[58:16] > 43'(SAT_LIM)) ? SAT_LIM : $signed(dsum[DW+15:16]);
    p2_ang_r  <= $signed(asum[44:16]);
    p2_ce_r   <= p1_ce_r;

    p3_side_r  <= p2_side_r;
    p3_mdc_r   <= p2_d0_r * p2_ce_r;
    p3_mterm_r <= $signed({1'b0, wheel_base_r}) * p2_ang_r;
    p3_vfwd_r  <= p2_vfwd_r;

    p4_side_r <= p3_side_r;
    p4_d1_r   <= sat38(64'($signed(dcs[55:16])));
    p4_term_r <= $signed(tms[53:17]);
    p4_vfwd_r <= p3_vfwd_r;

    p5_side_r <= p4_side_r;
    p5_diff_r <= sat38(64'(40'(p4_d1_r) - 40'(p4_vfwd_r)));
    p5_d1_r   <= p4_d1_r;
    p5_term_r <= p4_term_r;

    p6_side_r <= p5_side_r;
    p6_mkv_r  <= $signed({1'b0, vel_gain_r}) * p5_diff_r;
    p6_d1_r   <= p5_d1_r;
    p6_term_r <= p5_term_r;

    p7_side_r <= p6_side_r;
    p7_lin_r  <= sat38(64'(48'(p6_d1_r) + 48'($signed(kvs[62:16]))));
    p7_term_r <= p6_term_r;

    if (!rst_n) begin
      p1_side_r.valid <= 1'b0;
      p2_side_r.valid <= 1'b0;
      p3_side_r.valid <= 1'b0;
      p4_side_r.valid <= 1'b0;
      p5_side_r.valid <= 1'b0;
      p6_side_r.valid <= 1'b0;
      p7_side_r.valid <= 1'b0;
    end
  end

  // mix, clamp and divider set-up
  logic signed [DW:0]   wr, wl, lim_s;
  logic [CfgW-1:0]      mag_r, mag_l;
  logic [NumW-1:0]      num_r, num_l;
  ddg_div_t             p8_side_nxt, p8_side_r;
  logic [CfgW-1:0]      p8_rem_r_r, p8_rem_l_r;
  logic [DivSteps-1:0]  p8_nlo_r_r, p8_nlo_l_r;

  always_comb begin
    lim_s = $signed({{(DW+1-CfgW){1'b0}}, speed_limit_r});
    wr    = (DW+1)'(p7_lin_r) - (DW+1)'(p7_term_r);
    wl    = (DW+1)'(p7_lin_r) + (DW+1)'(p7_term_r);
    if (wr > lim_s) wr = lim_s;
    if (wr < -lim_s) wr = -lim_s;
    if (wl > lim_s) wl = lim_s;
    if (wl < -lim_s) wl = -lim_s;
    mag_r = (wr < 0) ? CfgW'(-wr) : CfgW'(wr);
    mag_l = (wl < 0) ? CfgW'(-wl) : CfgW'(wl);
    num_r = NumW'({mag_r, 15'b0}) + NumW'(speed_limit_r >> 1);
    num_l = NumW'({mag_l, 15'b0}) + NumW'(speed_limit_r >> 1);
    p8_side_nxt       = p7_side_r;
    p8_side_nxt.zlim  = (speed_limit_r == '0);
    p8_side_nxt.neg_r = (wr < 0);
    p8_side_nxt.neg_l = (wl < 0);
  end

  always_ff @(posedge clk) begin
    p8_side_r  <= p8_side_nxt;
    p8_rem_r_r <= num_r[NumW-1:DivSteps];
    p8_rem_l_r <= num_l[NumW-1:DivSteps];
    p8_nlo_r_r <= num_r[DivSteps-1:0];
    p8_nlo_l_r <= num_l[DivSteps-1:0];
    if (!rst_n) begin
      p8_side_r.valid <= 1'b0;
    end
  end

  // divider chain
  ddg_div_t            dst   [0:DivSteps];
  logic [CfgW-1:0]     drem_r [0:DivSteps];
  logic [CfgW-1:0]     drem_l [0:DivSteps];
  logic [DivSteps-1:0] dnlo_r [0:DivSteps];
  logic [DivSteps-1:0] dnlo_l [0:DivSteps];
  logic [DivSteps-1:0] dq_r   [0:DivSteps];
  logic [DivSteps-1:0] dq_l   [0:DivSteps];

  assign dst[0]    = p8_side_r;
  assign drem_r[0] = p8_rem_r_r;
  assign drem_l[0] = p8_rem_l_r;
  assign dnlo_r[0] = p8_nlo_r_r;
  assign dnlo_l[0] = p8_nlo_l_r;
  assign dq_r[0]   = '0;
  assign dq_l[0]   = '0;

  for (genvar gd = 0; gd < DivSteps; gd++) begin : g_div
    ddg_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .lim     (speed_limit_r),
      .st_i    (dst[gd]),
      .rem_r_i (drem_r[gd]),
      .rem_l_i (drem_l[gd]),
      .nlo_r_i (dnlo_r[gd]),
      .nlo_l_i (dnlo_l[gd]),
      .q_r_i   (dq_r[gd]),
      .q_l_i   (dq_l[gd]),
      .st_o    (dst[gd+1]),
      .rem_r_o (drem_r[gd+1]),
      .rem_l_o (drem_l[gd+1]),
      .nlo_r_o (dnlo_r[gd+1]),
      .nlo_l_o (dnlo_l[gd+1]),
      .q_r_o   (dq_r[gd+1]),
      .q_l_o   (dq_l[gd+1])
    );
  end

  // output stage
  ddg_div_t               fin;
  logic signed [CmdW-1:0] qr, ql, res_r_nxt, res_l_nxt, out_right_r, out_left_r;
  logic                   out_valid_r;

  always_comb begin
    fin = dst[DivSteps];
    qr  = $signed(CmdW'(dq_r[DivSteps]));
    ql  = $signed(CmdW'(dq_l[DivSteps]));
    if (!fin.track) begin
      res_r_nxt = fin.byp_r;
      res_l_nxt = fin.byp_l;
    end else if (fin.zlim) begin
      res_r_nxt = '0;
      res_l_nxt = '0;
    end else begin
      res_r_nxt = fin.neg_r ? -qr : qr;
      res_l_nxt = fin.neg_l ? -ql : ql;
    end
  end

  always_ff @(posedge clk) begin
    out_right_r <= res_r_nxt;
    out_left_r  <= res_l_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_right_cmd = out_right_r;
  assign out_left_cmd  = out_left_r;

  ap_right_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_right_cmd <= CMD_MAX && out_right_cmd >= -CMD_MAX))
    else $error("right command out of range");

  ap_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_cmd <= CMD_MAX && out_left_cmd >= -CMD_MAX))
    else $error("left command out of range");

  ap_cfg_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_SPEED_LIMIT) |=> (speed_limit_r == $past(cfg_data)))
    else $error("speed limit write lost");

endmodule
